FILE: rtl/assert_macros.svh
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check an implication on the next clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rmth_pkg.sv
`timescale 1ns / 1ps
package rmth_pkg;
   localparam int MEDIAN_BITS = 33;
   localparam int COUNT_BITS  = 11;
   localparam int DATA_BITS   = 32;

   // one-hot sequencer states
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_TOPRD  = 9'b000000010,
      ST_DECIDE = 9'b000000100,
      ST_UPRD   = 9'b000001000,
      ST_UPCMP  = 9'b000010000,
      ST_DNRD   = 9'b000100000,
      ST_DNCMP  = 9'b001000000,
      ST_TOPS   = 9'b010000000,
      ST_OUT    = 9'b100000000
   } state_type;

   // what the heap engine does for one insert
   typedef struct packed {
      logic push_lo;   // sift-up value into lower heap
      logic push_up;   // sift-up value into upper heap
      logic down_lo;   // replace lower top, sift down
      logic down_up;   // replace upper top, sift down
   } plan_type;
endpackage

FILE: rtl/running_median_two_heaps_unit.sv
`timescale 1ns / 1ps
// Running median unit.
// req_ channel: one signed sample per transaction in req_tdata[SAMPLE_BITS-1:0]
// (upper bits ignored). rsp_ channel: one result per sample, fields from bit 0:
// median_doubled (33, signed), sample_count (11), dropped (1), zero padded.
// Samples live in two simple dual-port synchronous memories, a max-heap of the
// lower half and a min-heap of the upper half. One sequencer walks the heaps: each
// heap level of a sift-up reads the parent, then compares and writes; each level
// of a sift-down reads the left child, takes it, reads the right child, then
// compares and swaps. A plain push only sifts up; when a top moves between heaps
// the moved value is sifted up and the new top is sifted down. A dropped sample
// skips the heaps and only reads the tops for the result.
// One sample is in flight at a time; req_tready is high only when idle.
// Reset clears counts and the sequencer; heap contents need no clearing since
// no entry's value is used before it is written. The result sits in an output
// register until rsp_tready; while it waits the unit does not take a new sample.
module running_median_two_heaps_unit #(
   parameter int CAPACITY    = 1024,
   parameter int SAMPLE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // median_doubled, sample_count, dropped
);
   localparam int LDEPTH = (CAPACITY + 1) / 2;
   localparam int UDEPTH = CAPACITY / 2;
   localparam int AW     = $clog2(LDEPTH) > 0 ? $clog2(LDEPTH) : 1;
   localparam int CW     = $clog2(LDEPTH + 1);
   localparam int TW     = $clog2(CAPACITY + 1);

   logic signed [31:0] lmem [LDEPTH];
   logic signed [31:0] umem [UDEPTH];

   rmth_pkg::state_type state_ff, state_in;
   rmth_pkg::plan_type  plan_ff, plan_in;
   logic [CW-1:0] lcnt_ff, lcnt_in, ucnt_ff, ucnt_in;
   logic signed [31:0] smp_ff, smp_in;   // value being sifted
   logic signed [31:0] val_ff, val_in;   // second value to place
   logic [AW:0] pos_ff, pos_in, lim_ff, lim_in;
   logic        sel_ff, sel_in;          // 0 lower heap, 1 upper heap
   logic        ph_ff, ph_in;            // child phase in sift-down
   logic signed [31:0] cl_ff, cl_in;     // left child value
   logic        drop_ff, drop_in;
   logic [47:0] out_ff, out_in;
   logic        ov_ff, ov_in;

   // memory port
   logic        we_l, we_u;
   logic [AW-1:0] ra, wa;
   logic signed [31:0] wd, rl_ff, ru_ff;
   logic signed [31:0] rd;
   logic signed [31:0] ltop_ff, ltop_in, utop_ff, utop_in;

   always_ff @(posedge clock) begin
      if (we_l) lmem[wa] <= wd;
      rl_ff <= lmem[ra];
   end
   always_ff @(posedge clock) begin
      if (we_u) umem[wa] <= wd;
      ru_ff <= umem[ra];
   end
   assign rd = sel_ff ? ru_ff : rl_ff;

   function automatic logic above(input logic up, input logic signed [31:0] a,
                                  input logic signed [31:0] b);
      return up ? (a < b) : (a > b);
   endfunction

   logic signed [31:0] s_in;
   logic [AW:0] parent, lchild;
   logic [TW-1:0] total;
   logic signed [32:0] med;

   assign s_in   = 32'($signed(req_tdata[SAMPLE_BITS-1:0]));
   assign parent = (pos_ff - 1'b1) >> 1;
   assign lchild = {pos_ff[AW-1:0], 1'b1};
   assign total  = TW'(lcnt_ff) + TW'(ucnt_ff);

   always_comb begin
      state_in = state_ff; plan_in = plan_ff; lcnt_in = lcnt_ff; ucnt_in = ucnt_ff;
      smp_in = smp_ff; val_in = val_ff; pos_in = pos_ff; lim_in = lim_ff;
      sel_in = sel_ff; ph_in = ph_ff; cl_in = cl_ff; drop_in = drop_ff;
      out_in = out_ff; ov_in = ov_ff; ltop_in = ltop_ff; utop_in = utop_ff;
      we_l = 1'b0; we_u = 1'b0; ra = '0; wa = '0; wd = smp_ff;
      med = '0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      unique case (state_ff)
         rmth_pkg::ST_IDLE: begin
            if (req_tvalid && !ov_ff) begin
               smp_in   = s_in;
               drop_in  = (total >= TW'(CAPACITY));
               state_in = (total >= TW'(CAPACITY)) ? rmth_pkg::ST_TOPS
                                                   : rmth_pkg::ST_DECIDE;
            end
         end
         rmth_pkg::ST_DECIDE: begin
            plan_in = '0;
            if (lcnt_ff == '0 || smp_ff <= ltop_ff) begin
               if (lcnt_ff > ucnt_ff) begin
                  plan_in.push_up = 1'b1; plan_in.down_lo = 1'b1;
                  val_in = smp_ff; smp_in = ltop_ff;
               end else plan_in.push_lo = 1'b1;
            end else if (ucnt_ff >= lcnt_ff) begin
               if (ucnt_ff == '0 || smp_ff <= utop_ff) plan_in.push_lo = 1'b1;
               else begin
                  plan_in.push_lo = 1'b1; plan_in.down_up = 1'b1;
                  val_in = smp_ff; smp_in = utop_ff;
               end
            end else plan_in.push_up = 1'b1;
            state_in = rmth_pkg::ST_TOPRD;
         end
         rmth_pkg::ST_TOPRD: begin
            // start the push: write at the end, sift up
            sel_in = plan_ff.push_up;
            if (plan_ff.push_up) begin
               pos_in = (AW+1)'(ucnt_ff); ucnt_in = ucnt_ff + 1'b1;
            end else begin
               pos_in = (AW+1)'(lcnt_ff); lcnt_in = lcnt_ff + 1'b1;
            end
            state_in = rmth_pkg::ST_UPRD;
         end
         rmth_pkg::ST_UPRD: begin
            ra = parent[AW-1:0];
            if (pos_ff == '0) begin
               wa = '0; we_l = !sel_ff; we_u = sel_ff;
               state_in = (plan_ff.down_lo || plan_ff.down_up) ? rmth_pkg::ST_DNRD
                                                               : rmth_pkg::ST_TOPS;
               if (plan_ff.down_lo || plan_ff.down_up) begin
                  sel_in = plan_ff.down_up; pos_in = '0; smp_in = val_ff; ph_in = 1'b0;
                  lim_in = (AW+1)'(plan_ff.down_up ? ucnt_ff : lcnt_ff);
               end
            end else state_in = rmth_pkg::ST_UPCMP;
         end
         rmth_pkg::ST_UPCMP: begin
            wa = pos_ff[AW-1:0];
            we_l = !sel_ff; we_u = sel_ff;
            if (above(sel_ff, smp_ff, rd)) begin
               wd = rd; pos_in = parent; state_in = rmth_pkg::ST_UPRD;
            end else begin
               wd = smp_ff;
               state_in = (plan_ff.down_lo || plan_ff.down_up) ? rmth_pkg::ST_DNRD
                                                               : rmth_pkg::ST_TOPS;
               if (plan_ff.down_lo || plan_ff.down_up) begin
                  sel_in = plan_ff.down_up; pos_in = '0; smp_in = val_ff; ph_in = 1'b0;
                  lim_in = (AW+1)'(plan_ff.down_up ? ucnt_ff : lcnt_ff);
               end
            end
         end
         rmth_pkg::ST_DNRD: begin
            // issue left, then right child reads
            ra = ph_ff ? (lchild[AW-1:0] + 1'b1) : lchild[AW-1:0];
            if (!ph_ff && ((AW+2)'(lchild) >= (AW+2)'(lim_ff)) ) begin
               wa = pos_ff[AW-1:0]; we_l = !sel_ff; we_u = sel_ff; wd = smp_ff;
               state_in = rmth_pkg::ST_TOPS;
            end else state_in = rmth_pkg::ST_DNCMP;
         end
         rmth_pkg::ST_DNCMP: begin
            if (!ph_ff) begin
               cl_in = rd; ph_in = 1'b1; state_in = rmth_pkg::ST_DNRD;
            end else begin
               ph_in = 1'b0; wa = pos_ff[AW-1:0]; we_l = !sel_ff; we_u = sel_ff;
               state_in = rmth_pkg::ST_DNRD;
               if ((AW+2)'(lchild) + 1'b1 < (AW+2)'(lim_ff) && above(sel_ff, rd, cl_ff)
                   && above(sel_ff, rd, smp_ff)) begin
                  wd = rd; pos_in = lchild + 1'b1;
               end else if (above(sel_ff, cl_ff, smp_ff)) begin
                  wd = cl_ff; pos_in = lchild;
               end else begin
                  wd = smp_ff; state_in = rmth_pkg::ST_TOPS;
               end
            end
         end
         rmth_pkg::ST_TOPS: begin
            ra = '0; sel_in = 1'b0; state_in = rmth_pkg::ST_OUT;
         end
         rmth_pkg::ST_OUT: begin
            ltop_in = rl_ff; utop_in = ru_ff;
            if (lcnt_ff == '0) med = '0;
            else if (lcnt_ff == ucnt_ff) med = 33'(rl_ff) + 33'(ru_ff);
            else med = {rl_ff, 1'b0};
            out_in = {3'b000, drop_ff, rmth_pkg::COUNT_BITS'(total), med};
            ov_in = 1'b1; state_in = rmth_pkg::ST_IDLE;
         end
         default: state_in = rmth_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmth_pkg::ST_IDLE; lcnt_ff <= '0; ucnt_ff <= '0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; lcnt_ff <= lcnt_in; ucnt_ff <= ucnt_in; ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff <= plan_in; smp_ff <= smp_in; val_ff <= val_in; pos_ff <= pos_in;
      lim_ff <= lim_in; sel_ff <= sel_in; ph_ff <= ph_in; cl_ff <= cl_in;
      drop_ff <= drop_in; out_ff <= out_in; ltop_ff <= ltop_in; utop_ff <= utop_in;
   end

   assign req_tready = (state_ff == rmth_pkg::ST_IDLE) && !ov_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;
endmodule

FILE: rtl/rmth_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rmth_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);
   `ASSERT_IMPLY(a_one_in_flight, clock, reset, rsp_tvalid, !req_tready, "ready while result pending")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `ASSERT_IMPLY(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[47:45] == 3'b000, "pad bits set")
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready, "second sample taken")
endmodule

bind running_median_two_heaps_unit rmth_checker u_rmth_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
   localparam int CAP = 1024;
   localparam int LO_DEPTH = (CAP + 1) / 2;
   localparam int UP_DEPTH = CAP / 2;
   localparam int RANDOM_ITEMS = 1750;

   typedef struct packed {
      logic                             dropped;
      logic [rmth_pkg::COUNT_BITS-1:0]  count;
      logic [rmth_pkg::MEDIAN_BITS-1:0] median;
   } median_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;

   running_median_two_heaps_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic signed [31:0] lo_heap [LO_DEPTH];
   logic signed [31:0] up_heap [UP_DEPTH];
   int lo_n, up_n;
   median_result_type pending_medians [$];
   int errors, sent, got, drops_seen;
   bit stimulus_done;
   bit hold_off;

   function automatic bit outranks(logic signed [31:0] a, logic signed [31:0] b, bit is_max);
      return is_max ? (a > b) : (a < b);
   endfunction

   task automatic heap_up(bit is_max, int pos);
      int parent;
      logic signed [31:0] t;
      while (pos > 0) begin
         parent = (pos - 1) / 2;
         if (is_max) begin
            if (!outranks(lo_heap[pos], lo_heap[parent], 1)) break;
            t = lo_heap[pos]; lo_heap[pos] = lo_heap[parent]; lo_heap[parent] = t;
         end else begin
            if (!outranks(up_heap[pos], up_heap[parent], 0)) break;
            t = up_heap[pos]; up_heap[pos] = up_heap[parent]; up_heap[parent] = t;
         end
         pos = parent;
      end
   endtask

   task automatic heap_down(bit is_max, int n);
      int pos, l, r, best;
      logic signed [31:0] t;
      pos = 0;
      forever begin
         l = 2 * pos + 1;
         r = l + 1;
         best = pos;
         if (is_max) begin
            if (l < n && outranks(lo_heap[l], lo_heap[best], 1)) best = l;
            if (r < n && outranks(lo_heap[r], lo_heap[best], 1)) best = r;
            if (best == pos) break;
            t = lo_heap[pos]; lo_heap[pos] = lo_heap[best]; lo_heap[best] = t;
         end else begin
            if (l < n && outranks(up_heap[l], up_heap[best], 0)) best = l;
            if (r < n && outranks(up_heap[r], up_heap[best], 0)) best = r;
            if (best == pos) break;
            t = up_heap[pos]; up_heap[pos] = up_heap[best]; up_heap[best] = t;
         end
         pos = best;
      end
   endtask

   task automatic push_lo(logic signed [31:0] v);
      if (lo_n >= LO_DEPTH) return;
      lo_heap[lo_n] = v;
      heap_up(1, lo_n);
      lo_n++;
   endtask

   task automatic push_up(logic signed [31:0] v);
      if (up_n >= UP_DEPTH) return;
      up_heap[up_n] = v;
      heap_up(0, up_n);
      up_n++;
   endtask

   task automatic predict_median(logic [31:0] raw, output median_result_type r);
      logic signed [31:0] s;
      logic signed [33:0] med;
      s = raw;
      r.dropped = (lo_n + up_n >= CAP);
      if (!r.dropped) begin
         if (lo_n == 0 || s <= lo_heap[0]) begin
            if (lo_n > up_n) begin
               push_up(lo_heap[0]);
               lo_heap[0] = s;
               heap_down(1, lo_n);
            end else push_lo(s);
         end else if (up_n >= lo_n) begin
            if (up_n == 0 || s <= up_heap[0]) push_lo(s);
            else begin
               push_lo(up_heap[0]);
               up_heap[0] = s;
               heap_down(0, up_n);
            end
         end else push_up(s);
      end
      med = '0;
      if (lo_n > 0)
         med = (lo_n == up_n) ? (34'(lo_heap[0]) + 34'(up_heap[0])) : (34'(lo_heap[0]) * 2);
      r.median = med[rmth_pkg::MEDIAN_BITS-1:0];
      r.count = rmth_pkg::COUNT_BITS'(lo_n + up_n);
   endtask

   // directed rows: sample, known flag, expected doubled median
   typedef struct {
      logic [31:0]       sample;
      bit                known;
      logic signed [32:0] median;
   } sample_row_type;

   sample_row_type sample_table [16] = '{
      '{32'h8000_0000, 1, -33'sd4294967296},
      '{32'h7fff_ffff, 1, -33'sd1},
      '{32'h7fff_ffff, 1, 33'sd4294967294},
      '{32'h8000_0000, 1, -33'sd1},
      '{32'h0000_0000, 0, 0},
      '{32'h0000_0000, 0, 0},
      '{32'hffff_ffff, 0, 0},
      '{32'h0000_0001, 0, 0},
      '{32'h0000_0001, 0, 0},
      '{32'hffff_ffff, 0, 0},
      '{32'h5555_5555, 0, 0},
      '{32'haaaa_aaaa, 0, 0},
      '{32'h0000_0000, 0, 0},
      '{32'h7fff_fffe, 0, 0},
      '{32'h8000_0001, 0, 0},
      '{32'h1234_5678, 0, 0}
   };

   // entered and left at a falling edge; valid stays up into a zero gap
   task automatic send_sample(logic [31:0] v, bit known, logic signed [32:0] want);
      median_result_type r;
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= v;
      do @(posedge clock); while (!req_tready);
      predict_median(v, r);
      if (known && r.median !== want) begin
         $error("median_doubled: expected %0d actual %0d", want, $signed(r.median));
         errors++;
      end
      pending_medians.push_back(r);
      sent++;
      @(negedge clock);
   endtask

   // sample mostly in narrow bands so ties and equal tops are common
   function automatic logic [31:0] draw_sample();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 40)) - 20);
         2: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                        : 32'h8000_0000 + $urandom_range(0, 3);
         default: return 32'($signed($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   initial begin
      lo_n = 0; up_n = 0; errors = 0; sent = 0; got = 0; drops_seen = 0;
      stimulus_done = 0; hold_off = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (sample_table[i])
         send_sample(sample_table[i].sample, sample_table[i].known, sample_table[i].median);
      for (int i = 0; i < RANDOM_ITEMS; i++)
         send_sample(draw_sample(), 0, 0);
      req_tvalid <= 1'b0;
      stimulus_done = 1;
   end

   // receiver, with one long hold-off while the sender keeps offering
   initial begin
      int stall;
      median_result_type want, seen;
      wait (!reset);
      forever begin
         if (sent == 40 && !hold_off) begin
            hold_off = 1;
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
         end
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         seen = rsp_tdata[44:0];
         got++;
         if (seen.dropped) drops_seen++;
         if (pending_medians.size() == 0) begin
            $error("result with nothing pending");
            errors++;
         end else begin
            want = pending_medians.pop_front();
            if (seen.median !== want.median) begin
               $error("median_doubled: expected %0d actual %0d",
                      $signed(want.median), $signed(seen.median));
               errors++;
            end
            if (seen.count !== want.count) begin
               $error("sample_count: expected %0d actual %0d", want.count, seen.count);
               errors++;
            end
            if (seen.dropped !== want.dropped) begin
               $error("dropped: expected %0d actual %0d", want.dropped, seen.dropped);
               errors++;
            end
         end
      end
   end

   initial begin
      wait (stimulus_done);
      wait (pending_medians.size() == 0);
      repeat (200) @(posedge clock);
      if (pending_medians.size() != 0) errors++;
      $display("Sent %0d samples, checked %0d results, %0d of them dropped on a full store.",
               sent, got, drops_seen);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #50ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
